>>> sv/bda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types, constants and the power-of-ten table for the binary to
// decimal ASCII converter.
// ----------------------------------------------------------------------------
package bda_pkg;

	localparam int VALUE_W    = 32;
	localparam int WIDE_W     = 34;   // holds 9 x 10^9
	localparam int DIGIT_W    = 4;
	localparam int CHAR_W     = 6;
	localparam int IDX_W      = 4;
	localparam int NUM_DIGITS = 10;

	localparam logic [IDX_W-1:0]  TOP_IDX    = IDX_W'(NUM_DIGITS - 1);
	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic step;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic slot_free;
		logic final_step;
	} sts_t;

	// 10^k for the digit position being resolved
	function automatic logic [WIDE_W-1:0] pow10(input logic [IDX_W-1:0] k);
		logic [WIDE_W-1:0] p;
		begin
			case (k)
				4'd0:    p = 34'd1;
				4'd1:    p = 34'd10;
				4'd2:    p = 34'd100;
				4'd3:    p = 34'd1000;
				4'd4:    p = 34'd10000;
				4'd5:    p = 34'd100000;
				4'd6:    p = 34'd1000000;
				4'd7:    p = 34'd10000000;
				4'd8:    p = 34'd100000000;
				4'd9:    p = 34'd1000000000;
				default: p = 34'd0;
			endcase
			return p;
		end
	endfunction

endpackage
`default_nettype wire

>>> sv/binary_to_decimal_ascii_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top
// Unsigned 32-bit binary to decimal ASCII digit stream.
// ----------------------------------------------------------------------------
// Input channel: value with in_valid / in_ready. One transaction per number.
// Output channel: digit_char / last_digit with out_valid / out_ready, one
// transaction per decimal digit, most significant first, leading zeros
// dropped, a single '0' for zero, last_digit set on the final digit.
// Each number walks ten digit positions, one per cycle while the output slot
// is free, through a compare against the nine multiples of the current power
// of ten; positions holding leading zeros take a step but produce nothing. A
// number therefore takes an accept and ten digit steps. The first digit comes
// from the first step for a ten-digit value, and from the last one for zero.
// in_ready is high only between numbers. A digit waits in the output register
// while out_ready is low, and the stepping pauses until the slot frees; the
// next value is accepted while the final digit is still waiting.
// Reset clears the sequencer, the digit position, the started flag and the output valid; no memory is cleared.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [bda_pkg::VALUE_W-1:0] value,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [bda_pkg::CHAR_W-1:0]       digit_char,
	output logic                             last_digit
);

	bda_pkg::cmd_t cmd;
	bda_pkg::sts_t sts;

	bda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bda_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digit_char (digit_char),
		.last_digit (last_digit)
	);

	// No second number is taken straight after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a number is in conversion");

	// Every result is a decimal digit character
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (digit_char >= 6'd48 && digit_char <= 6'd57))
		else $error("digit character out of range");

	// The converter only goes idle after producing a final digit
	a_last_before_idle: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(in_ready) && $past(arst_n)) |-> (out_valid && last_digit))
		else $error("converter went idle without a final digit");

endmodule
`default_nettype wire

>>> sv/bda_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bda_ctrl
// Sequencer: takes a value, then steps the datapath once per digit position
// whenever the output slot can take a result.
// ----------------------------------------------------------------------------
module bda_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire bda_pkg::sts_t sts,
	output bda_pkg::cmd_t      cmd
);

	bda_pkg::state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			bda_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = bda_pkg::ST_RUN;
				end
			end
			bda_pkg::ST_RUN: begin
				if (sts.slot_free) begin
					cmd.step = 1'b1;
					if (sts.final_step) begin
						state_d = bda_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = bda_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> sv/bda_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bda_dpath
// Remainder register, digit position counter and output register. Each step
// resolves one decimal digit, most significant first, by comparing the
// remainder against the nine multiples of the current power of ten.
// ----------------------------------------------------------------------------
module bda_dpath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire bda_pkg::cmd_t                   cmd,
	output bda_pkg::sts_t                        sts,
	input  wire logic [bda_pkg::VALUE_W-1:0]     value,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [bda_pkg::CHAR_W-1:0]           digit_char,
	output logic                                 last_digit
);

	logic [bda_pkg::VALUE_W-1:0] rem_q;
	logic [bda_pkg::IDX_W-1:0]   pos_q;
	logic                        started_q;
	logic                        out_valid_q;
	logic [bda_pkg::CHAR_W-1:0]  char_q;
	logic                        last_q;

	logic [bda_pkg::WIDE_W-1:0]  p10;
	logic [bda_pkg::WIDE_W-1:0]  mult [0:9];
	logic [9:1]                  ge;
	logic [bda_pkg::DIGIT_W-1:0] dig;
	logic [bda_pkg::WIDE_W-1:0]  sub;
	logic [bda_pkg::VALUE_W-1:0] rem_next;
	logic                        emit;

	// Multiples of 10^k and the thermometer of compares
	assign p10     = bda_pkg::pow10(pos_q);
	assign mult[0] = '0;
	for (genvar m = 1; m <= 9; m++) begin : g_mult
		assign mult[m] = p10 * bda_pkg::WIDE_W'(m);
		assign ge[m]   = {2'b00, rem_q} >= mult[m];
	end

	// Digit is the count of multiples that fit
	always_comb begin
		dig      = bda_pkg::DIGIT_W'($countones(ge));
		sub      = mult[dig];
		rem_next = rem_q - sub[bda_pkg::VALUE_W-1:0];
		emit     = started_q || (dig != '0) || (pos_q == '0);
	end

	assign sts.slot_free  = !out_valid_q || out_ready;
	assign sts.final_step = (pos_q == '0);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			started_q   <= 1'b0;
			pos_q       <= '0;
		end else begin
			if (cmd.load) begin
				started_q <= 1'b0;
				pos_q     <= bda_pkg::TOP_IDX;
			end else if (cmd.step) begin
				started_q <= emit;
				pos_q     <= pos_q - 1'b1;
			end
			if (cmd.step && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= value;
		end else if (cmd.step) begin
			rem_q <= rem_next;
		end
		if (cmd.step && emit) begin
			char_q <= bda_pkg::ASCII_ZERO + bda_pkg::CHAR_W'(dig);
			last_q <= (pos_q == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = char_q;
	assign last_digit = last_q;

endmodule
`default_nettype wire

>>> test/binary_to_decimal_ascii_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_checker
// Watches both channels of the converter. For every number accepted on the
// input it queues the expected decimal digits as ASCII, and it compares each
// digit leaving the block with the oldest one queued.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic                        in_ready,
	input  wire logic [bda_pkg::VALUE_W-1:0] value,
	input  wire logic                        out_valid,
	input  wire logic                        out_ready,
	input  wire logic [bda_pkg::CHAR_W-1:0]  digit_char,
	input  wire logic                        last_digit,
	output int                               error_count,
	output int                               digits_pending,
	output int                               numbers_seen,
	output int                               digits_seen
);

	localparam logic [bda_pkg::VALUE_W-1:0] RADIX      = bda_pkg::VALUE_W'(10);
	localparam int                          REPORT_MAX = 10;

	typedef struct packed {
		logic [bda_pkg::CHAR_W-1:0] char_code;
		logic                       final_flag;
	} digit_t;

	digit_t expected_digits [$];
	int     fail_total   = 0;
	int     number_total = 0;
	int     digit_total  = 0;

	// Decimal expansion of one number, most significant digit first
	function automatic void queue_digits(input logic [bda_pkg::VALUE_W-1:0] number);
		logic [bda_pkg::VALUE_W-1:0] rest;
		logic [bda_pkg::DIGIT_W-1:0] rev [bda_pkg::NUM_DIGITS];
		int                          count;
		rest  = number;
		count = 0;
		do begin
			rev[count] = bda_pkg::DIGIT_W'(rest % RADIX);
			rest       = rest / RADIX;
			count++;
		end while (rest != '0 && count < bda_pkg::NUM_DIGITS);
		for (int k = count - 1; k >= 0; k--) begin
			expected_digits.push_back('{
				char_code:  bda_pkg::ASCII_ZERO + bda_pkg::CHAR_W'(rev[k]),
				final_flag: (k == 0)});
		end
	endfunction

	// Output side first: a digit never belongs to a number taken on the same edge
	always @(posedge clk) begin
		digit_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				digit_total++;
				if (expected_digits.size() == 0) begin
					fail_total++;
					if (fail_total <= REPORT_MAX)
						$display("%0t: unexpected digit char=%0d last=%0b", $time,
							digit_char, last_digit);
				end else begin
					want = expected_digits.pop_front();
					if (digit_char !== want.char_code ||
						last_digit !== want.final_flag) begin
						fail_total++;
						if (fail_total <= REPORT_MAX)
							$display({"%0t: digit mismatch: expected char=%0d last=%0b,",
								" got char=%0d last=%0b"}, $time, want.char_code,
								want.final_flag, digit_char, last_digit);
					end
				end
			end
			if (in_valid && in_ready) begin
				number_total++;
				queue_digits(value);
			end
		end
		error_count    <= fail_total;
		digits_pending <= expected_digits.size();
		numbers_seen   <= number_total;
		digits_seen    <= digit_total;
	end

endmodule

>>> test/binary_to_decimal_ascii_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top_test
// Drives numbers into the binary to decimal ASCII converter: a directed set
// of edge values, then random values of every digit length under three
// patterns of sender gaps and receiver stalls. Checking sits in the checker.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_top_test;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 24;
	localparam int PHASE_ITEMS    = 96;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic [bda_pkg::VALUE_W-1:0] value     = '0;
	logic                        out_ready = 1'b0;
	logic                        in_ready;
	logic                        out_valid;
	logic [bda_pkg::CHAR_W-1:0]  digit_char;
	logic                        last_digit;

	int error_count;
	int digits_pending;
	int numbers_seen;
	int digits_seen;
	int send_gap_pct  = 0;
	int recv_stall_pct = 0;
	int quiet_cycles  = 0;

	binary_to_decimal_ascii_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digit_char (digit_char),
		.last_digit (last_digit)
	);

	binary_to_decimal_ascii_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.value          (value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.digit_char     (digit_char),
		.last_digit     (last_digit),
		.error_count    (error_count),
		.digits_pending (digits_pending),
		.numbers_seen   (numbers_seen),
		.digits_seen    (digits_seen)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Receiver stalls
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d idle cycles", quiet_cycles);
			$display("binary_to_decimal_ascii_top_test: done, errors");
			$finish;
		end
	end

	// One number per transaction, with random gaps ahead of it
	task automatic send_number(input logic [bda_pkg::VALUE_W-1:0] number);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= number;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Random number biased towards every digit length and powers of ten
	function automatic logic [bda_pkg::VALUE_W-1:0] random_number();
		logic [bda_pkg::VALUE_W-1:0] scale;
		int                          pick;
		pick = $urandom_range(9);
		if (pick < 5)
			return $urandom >> $urandom_range(bda_pkg::VALUE_W - 1);
		if (pick < 8)
			return $urandom;
		scale = 1;
		repeat ($urandom_range(bda_pkg::NUM_DIGITS - 1))
			scale = scale * 10;
		return scale + bda_pkg::VALUE_W'($urandom_range(2)) - 1 +
			(scale * $urandom_range(3));
	endfunction

	task automatic run_phase(input int gap_pct, input int stall_pct, input int count);
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
		repeat (count)
			send_number(random_number());
	endtask

	initial begin
		logic [bda_pkg::VALUE_W-1:0] directed [$];
		directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd4294967295,
			32'd4294967294, 32'd1000000000, 32'd999999999, 32'd4000000000,
			32'd100000000, 32'd10000000, 32'd1000000001, 32'd2147483648,
			32'h5555_5555, 32'hAAAA_AAAA, 32'd4294967290, 32'd12, 32'd20,
			32'd3000000003, 32'd0};

		// Hold reset, then release it
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Edge values, no gaps or stalls
		foreach (directed[i])
			send_number(directed[i]);

		run_phase(25, 54, PHASE_ITEMS);
		run_phase(54, 25, PHASE_ITEMS);
		run_phase(0, 0, PHASE_ITEMS);
		in_valid <= 1'b0;

		// Drain, then let the block settle
		do
			@(posedge clk);
		while (digits_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d numbers into %0d digit transactions, %0d failures",
			numbers_seen, digits_seen, error_count);
		$display("Covered edge values and random lengths under sender gaps, receiver stalls and none");
		if (error_count == 0)
			$display("binary_to_decimal_ascii_top_test: done, clean");
		else
			$display("binary_to_decimal_ascii_top_test: done, errors");
		$finish;
	end

endmodule
